// ===== sv/efr_pkg.sv =====
// shared constants and crc helper for the escaped frame receiver
package efr_pkg;

    localparam logic [7:0]  STX_BYTE   = 8'h02;
    localparam logic [7:0]  ENQ_BYTE   = 8'h10;
    localparam logic [7:0]  ESC_OFFSET = 8'h80;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;

    localparam logic [15:0] MAX_LENGTH_RESET    = 16'd4096;
    localparam logic [15:0] CRC_POLY_RESET      = 16'h1021;
    localparam logic        CRC_REFLECTED_RESET = 1'b0;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LENGTH    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CRC_POLY      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CRC_REFLECTED = 2'd2;

    localparam logic [2:0] KIND_DATA      = 3'd0;
    localparam logic [2:0] KIND_OK        = 3'd1;
    localparam logic [2:0] KIND_BAD_START = 3'd2;
    localparam logic [2:0] KIND_TOO_LONG  = 3'd3;
    localparam logic [2:0] KIND_CRC_ERROR = 3'd4;

    function automatic logic [15:0] reverse16(input logic [15:0] v);
        logic [15:0] r;
        for (int i = 0; i < 16; i++) begin
            r[i] = v[15-i];
        end
        return r;
    endfunction

    // one byte through the crc, msb first or reflected
    function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                               input logic [7:0]  b,
                                               input logic [15:0] poly,
                                               input logic        reflected);
        logic [15:0] crc;
        logic [15:0] rp;
        rp = reverse16(poly);
        if (reflected) begin
            crc = crc_in ^ {8'h00, b};
            for (int i = 0; i < 8; i++) begin
                crc = crc[0] ? ((crc >> 1) ^ rp) : (crc >> 1);
            end
        end else begin
            crc = crc_in ^ {b, 8'h00};
            for (int i = 0; i < 8; i++) begin
                crc = crc[15] ? ((crc << 1) ^ poly) : (crc << 1);
            end
        end
        return crc;
    endfunction

endpackage

// ===== sv/escaped_frame_receiver_unit.sv =====
// escaped frame receiver: byte-stuffed frame decoder with crc-16 check
//
// input channel s_valid/s_ready/s_rx_byte carries one raw line byte per item.
// result channel m_valid/m_ready carries zero or one result item per input
// item: a decoded payload byte (with m_last_byte on the final one), a frame
// ok or crc error report, a bad start report or a too long report.
// frames are stx, 16-bit big-endian length, payload and 16-bit crc; any byte
// after stx may be escaped by enq, the next byte minus 0x80 being the value.
// configuration is a plain write port: cfg_wr_en, cfg_index, cfg_wdata;
// index 0 max_length, 1 crc_poly, 2 crc_reflected.
// an item is decoded in the cycle it is accepted and its result is registered
// and shows on the m_ side in the next cycle; one item is taken every cycle
// while s_ready is high, limited by the single byte-wide crc and phase
// update between the input and the result register.
// s_ready is low only while a result is held and m_ready is low, so a
// stalled receiver holds the result and the input waits.
// after reset the block waits for stx, crc is 0xffff and the registers take
// max_length 4096, crc_poly 0x1021, crc_reflected 0.
module escaped_frame_receiver_unit
    import efr_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]            cfg_wdata,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_rx_byte,

    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [2:0]             m_kind,
    output logic [7:0]             m_data,
    output logic                   m_last_byte,
    output logic [15:0]            m_frame_length,
    output logic [15:0]            m_crc_calc,
    output logic [15:0]            m_crc_recv
);

    typedef enum logic [2:0] {
        PH_WAIT,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_PAYLOAD,
        PH_CRC_HI,
        PH_CRC_LO
    } phase_t;

    logic [15:0] max_length_reg;
    logic [15:0] crc_poly_reg;
    logic        crc_reflected_reg;

    phase_t      phase_reg, phase_next;
    logic        esc_reg, esc_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] seen_reg, seen_next;
    logic [7:0]  crc_high_reg, crc_high_next;

    logic        m_valid_reg, m_valid_next;
    logic [2:0]  kind_reg, kind_next;
    logic [7:0]  data_reg, data_next;
    logic        last_reg, last_next;
    logic [15:0] flen_reg, flen_next;
    logic [15:0] calc_reg, calc_next;
    logic [15:0] recv_reg, recv_next;

    logic        accept;
    logic        emit;
    logic [7:0]  b;
    logic [7:0]  v;
    logic [15:0] len_full;
    logic [15:0] seen_inc;
    logic [15:0] recv_full;
    logic [15:0] crc_step;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign b       = s_rx_byte;
    assign v       = esc_reg ? (b - ESC_OFFSET) : b;
    assign len_full  = {len_reg[15:8], v};
    assign seen_inc  = seen_reg + 16'd1;
    assign recv_full = {crc_high_reg, v};
    assign crc_step  = crc_update((phase_reg == PH_WAIT) ? CRC_INIT : crc_reg, b,
                                  crc_poly_reg, crc_reflected_reg);

    always_comb begin
        phase_next    = phase_reg;
        esc_next      = esc_reg;
        crc_next      = crc_reg;
        len_next      = len_reg;
        seen_next     = seen_reg;
        crc_high_next = crc_high_reg;
        emit          = 1'b0;
        kind_next     = kind_reg;
        data_next     = 8'h00;
        last_next     = 1'b0;
        flen_next     = len_reg;
        calc_next     = 16'h0000;
        recv_next     = 16'h0000;

        if (accept) begin
            if (phase_reg == PH_WAIT) begin
                if (b != STX_BYTE) begin
                    emit      = 1'b1;
                    kind_next = KIND_BAD_START;
                    flen_next = 16'h0000;
                end else begin
                    crc_next   = crc_step;
                    esc_next   = 1'b0;
                    len_next   = 16'h0000;
                    seen_next  = 16'h0000;
                    phase_next = PH_LEN_HI;
                end
            end else begin
                if (phase_reg != PH_CRC_HI && phase_reg != PH_CRC_LO) begin
                    crc_next = crc_step;
                end
                if (!esc_reg && b == ENQ_BYTE) begin
                    esc_next = 1'b1;
                end else begin
                    esc_next = 1'b0;
                    case (phase_reg)
                        PH_LEN_HI: begin
                            len_next   = {v, 8'h00};
                            phase_next = PH_LEN_LO;
                        end
                        PH_LEN_LO: begin
                            len_next = len_full;
                            if (len_full > max_length_reg) begin
                                emit       = 1'b1;
                                kind_next  = KIND_TOO_LONG;
                                flen_next  = len_full;
                                phase_next = PH_WAIT;
                                esc_next   = 1'b0;
                                crc_next   = CRC_INIT;
                            end else begin
                                seen_next  = 16'h0000;
                                phase_next = (len_full == 16'h0000) ? PH_CRC_HI
                                                                    : PH_PAYLOAD;
                            end
                        end
                        PH_PAYLOAD: begin
                            seen_next = seen_inc;
                            emit      = 1'b1;
                            kind_next = KIND_DATA;
                            data_next = v;
                            if (seen_inc >= len_reg) begin
                                last_next  = 1'b1;
                                phase_next = PH_CRC_HI;
                            end
                        end
                        PH_CRC_HI: begin
                            crc_high_next = v;
                            phase_next    = PH_CRC_LO;
                        end
                        PH_CRC_LO: begin
                            emit       = 1'b1;
                            kind_next  = (recv_full == crc_reg) ? KIND_OK
                                                                : KIND_CRC_ERROR;
                            calc_next  = crc_reg;
                            recv_next  = recv_full;
                            phase_next = PH_WAIT;
                            esc_next   = 1'b0;
                            crc_next   = CRC_INIT;
                        end
                        default: begin
                            phase_next = PH_WAIT;
                        end
                    endcase
                end
            end
        end

        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_length_reg    <= MAX_LENGTH_RESET;
            crc_poly_reg      <= CRC_POLY_RESET;
            crc_reflected_reg <= CRC_REFLECTED_RESET;
            phase_reg         <= PH_WAIT;
            esc_reg           <= 1'b0;
            crc_reg           <= CRC_INIT;
            len_reg           <= 16'h0000;
            seen_reg          <= 16'h0000;
            crc_high_reg      <= 8'h00;
            m_valid_reg       <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_MAX_LENGTH:    max_length_reg    <= cfg_wdata;
                    CFG_CRC_POLY:      crc_poly_reg      <= cfg_wdata;
                    CFG_CRC_REFLECTED: crc_reflected_reg <= cfg_wdata[0];
                    default: ;
                endcase
            end
            phase_reg    <= phase_next;
            esc_reg      <= esc_next;
            crc_reg      <= crc_next;
            len_reg      <= len_next;
            seen_reg     <= seen_next;
            crc_high_reg <= crc_high_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // result payload, loaded only when a new item is produced
    always_ff @(posedge aclk) begin
        if (emit) begin
            kind_reg <= kind_next;
            data_reg <= data_next;
            last_reg <= last_next;
            flen_reg <= flen_next;
            calc_reg <= calc_next;
            recv_reg <= recv_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_kind         = kind_reg;
    assign m_data         = data_reg;
    assign m_last_byte    = last_reg;
    assign m_frame_length = flen_reg;
    assign m_crc_calc     = calc_reg;
    assign m_crc_recv     = recv_reg;

endmodule
